// ===== rtl/core/c_keyword_counter_top_assert.svh =====
// Assertion macros for the keyword counter.
// Used by c_keyword_counter_top; no other dependencies.
`ifndef C_KEYWORD_COUNTER_TOP_ASSERT_SVH
`define C_KEYWORD_COUNTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define KC_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define KC_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("%m failed");
`else
`define KC_ASSERT_IMPL(label, clk, rst, prop)
`define KC_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== rtl/core/ckc_pkg.sv =====
// Package for the keyword counter: states, lexer modes and the keyword table.
// No dependencies.
package ckc_pkg;
   localparam int NumKeys    = 32;
   localparam int KeyW       = 5;
   localparam int CountW     = 16;
   localparam int MaxWord    = 100;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_WORD, MODE_SLASH, MODE_COMMENT, MODE_STAR, MODE_QUOTE
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_UPDATE, ST_REPORT, ST_MARKER, ST_WAIT
   } state_type;

   // Keyword bytes, first character in the low byte, zero padded.
   function automatic logic [63:0] kw_word(input logic [KeyW-1:0] k);
      logic [63:0] w;
      case (k)
         5'd0:  w = 64'h6f747561;
         5'd1:  w = 64'h6b61657262;
         5'd2:  w = 64'h65736163;
         5'd3:  w = 64'h72616863;
         5'd4:  w = 64'h74736e6f63;
         5'd5:  w = 64'h65756e69746e6f63;
         5'd6:  w = 64'h746c7561666564;
         5'd7:  w = 64'h6f64;
         5'd8:  w = 64'h656c62756f64;
         5'd9:  w = 64'h65736c65;
         5'd10: w = 64'h6d756e65;
         5'd11: w = 64'h6e7265747865;
         5'd12: w = 64'h74616f6c66;
         5'd13: w = 64'h726f66;
         5'd14: w = 64'h6f746f67;
         5'd15: w = 64'h6669;
         5'd16: w = 64'h746e69;
         5'd17: w = 64'h676e6f6c;
         5'd18: w = 64'h7265747369676572;
         5'd19: w = 64'h6e7275746572;
         5'd20: w = 64'h74726f6873;
         5'd21: w = 64'h64656e676973;
         5'd22: w = 64'h666f657a6973;
         5'd23: w = 64'h636974617473;
         5'd24: w = 64'h746375727473;
         5'd25: w = 64'h686374697773;
         5'd26: w = 64'h66656465707974;
         5'd27: w = 64'h6e6f696e75;
         5'd28: w = 64'h64656e6769736e75;
         5'd29: w = 64'h64696f76;
         5'd30: w = 64'h656c6974616c6f76;
         default: w = 64'h656c696877;
      endcase
      return w;
   endfunction
endpackage

// ===== rtl/core/c_keyword_counter_top.sv =====
// C keyword counter top level: lexer, binary search sequencer, count memory.
// Depends on ckc_pkg and c_keyword_counter_top_assert.svh.
// Input: a byte that ends a word is stored and then replayed to start a token. A byte
// that ends a keyword-candidate word holds the input through the transfer, the search
// compares, the count write and the token start. End of text: the same search, then a
// scan of all count entries, the marker and a release step, plus any receiver stalls.
// Reset: synchronous, active high; clears lexer state and all counts at once.
`include "c_keyword_counter_top_assert.svh"
module c_keyword_counter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [4:0] keyword_index, [20:5] hit_count, zeros
   output logic        rsp_tuser,   // [0] entry_valid
   output logic        rsp_tlast    // last
);
   localparam int KW = ckc_pkg::KeyW;
   localparam int CW = ckc_pkg::CountW;

   ckc_pkg::state_type st_ff, st_in;
   ckc_pkg::mode_type  mode_ff, mode_in;
   logic        dq_ff, dq_in, esc_ff, esc_in;
   logic [63:0] wchars_ff, wchars_in;
   logic [6:0]  wlen_ff, wlen_in;
   logic        walpha_ff, walpha_in;
   logic        eot_ff, eot_in;
   logic [7:0]  pend_ff, pend_in;
   logic        pend_v_ff, pend_v_in;
   logic [KW:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [KW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff [ckc_pkg::NumKeys];
   logic [ckc_pkg::NumKeys-1:0] nz_ff;
   logic        cnt_we, clr_all;
   logic [KW-1:0] cnt_wa;
   logic        rv_ff, rv_in, re_ff, re_in, rl_ff, rl_in;
   logic [KW-1:0] ri_ff, ri_in;
   logic [CW-1:0] rc_ff, rc_in;

   logic [7:0] c;
   logic is_alpha, is_digit, is_space;
   logic [KW-1:0] mid;
   logic [63:0] kw;
   logic lt, eq;

   assign c = req_tdata;
   assign is_alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   assign is_digit = c >= 8'h30 && c <= 8'h39;
   assign is_space = c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
   assign mid = KW'((lo_ff + hi_ff) >> 1);
   assign kw  = ckc_pkg::kw_word(mid);

   // Shared compare unit: bytewise string compare, low byte first.
   always_comb begin
      lt = 1'b0;
      eq = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         if (wchars_ff[8*i +: 8] != kw[8*i +: 8]) begin
            eq = 1'b0;
            lt = wchars_ff[8*i +: 8] < kw[8*i +: 8];
         end
      end
   end

   assign req_tready = (st_ff == ckc_pkg::ST_IDLE) && !pend_v_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {3'b0, rc_ff, ri_ff};
   assign rsp_tuser  = re_ff;
   assign rsp_tlast  = rl_ff;

   // Lexer and sequencer.
   always_comb begin
      logic [7:0] t;
      logic       do_tok, do_fin;
      st_in = st_ff; mode_in = mode_ff; dq_in = dq_ff; esc_in = esc_ff;
      wchars_in = wchars_ff; wlen_in = wlen_ff; walpha_in = walpha_ff;
      eot_in = eot_ff; pend_in = pend_ff; pend_v_in = pend_v_ff;
      lo_in = lo_ff; hi_in = hi_ff; idx_in = idx_ff;
      rv_in = rv_ff; re_in = re_ff; rl_in = rl_ff; ri_in = ri_ff; rc_in = rc_ff;
      cnt_we = 1'b0; cnt_wa = mid; clr_all = 1'b0;
      do_tok = 1'b0; do_fin = 1'b0;
      t = pend_ff;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      case (st_ff)
         ckc_pkg::ST_IDLE: begin
            if (pend_v_ff) begin
               pend_v_in = 1'b0;
               do_tok = 1'b1;
            end else if (req_tvalid) begin
               t = c;
               if (req_tuser) begin
                  eot_in = 1'b1;
                  if (mode_ff == ckc_pkg::MODE_WORD) do_fin = 1'b1;
                  else begin
                     st_in = ckc_pkg::ST_REPORT; idx_in = '0;
                  end
               end else begin
                  case (mode_ff)
                     ckc_pkg::MODE_WORD: begin
                        if ((is_alpha || is_digit || c == 8'h5f) &&
                            wlen_ff < 7'(ckc_pkg::MaxWord - 1)) begin
                           if (wlen_ff < 7'd8) wchars_in[8*wlen_ff[2:0] +: 8] = c;
                           wlen_in = wlen_ff + 7'd1;
                        end else begin
                           do_fin = 1'b1; pend_in = c; pend_v_in = 1'b1;
                        end
                     end
                     ckc_pkg::MODE_SLASH: begin
                        if (c == 8'h2a) mode_in = ckc_pkg::MODE_COMMENT;
                        else do_tok = 1'b1;
                     end
                     ckc_pkg::MODE_COMMENT:
                        if (c == 8'h2a) mode_in = ckc_pkg::MODE_STAR;
                     ckc_pkg::MODE_STAR: begin
                        if (c == 8'h2f) mode_in = ckc_pkg::MODE_IDLE;
                        else if (c != 8'h2a) mode_in = ckc_pkg::MODE_COMMENT;
                     end
                     ckc_pkg::MODE_QUOTE: begin
                        if (esc_ff) esc_in = 1'b0;
                        else if (c == 8'h5c) esc_in = 1'b1;
                        else if (c == (dq_ff ? 8'h22 : 8'h27)) mode_in = ckc_pkg::MODE_IDLE;
                     end
                     default: do_tok = 1'b1;
                  endcase
               end
            end
            // Finish word: start the search or drop the word.
            if (do_fin) begin
               mode_in = ckc_pkg::MODE_IDLE;
               if (walpha_ff && wlen_ff <= 7'd8) begin
                  st_in = ckc_pkg::ST_SEARCH;
                  lo_in = '0; hi_in = (KW+1)'(ckc_pkg::NumKeys - 1);
               end else begin
                  wchars_in = '0; wlen_in = '0; walpha_in = 1'b0;
                  if (req_tuser && !pend_v_in) begin
                     st_in = ckc_pkg::ST_REPORT; idx_in = '0;
                  end
               end
            end
            // Start a token from t.
            if (do_tok) begin
               mode_in = ckc_pkg::MODE_IDLE;
               if (is_space && t == c && !pend_v_ff) mode_in = ckc_pkg::MODE_IDLE;
               else if ((t >= 8'h61 && t <= 8'h7a) || (t >= 8'h41 && t <= 8'h5a) ||
                        t == 8'h5f || t == 8'h23) begin
                  mode_in = ckc_pkg::MODE_WORD;
                  wchars_in = {56'b0, t}; wlen_in = 7'd1;
                  walpha_in = t != 8'h5f && t != 8'h23;
               end else if (t == 8'h27 || t == 8'h22) begin
                  mode_in = ckc_pkg::MODE_QUOTE; dq_in = t == 8'h22; esc_in = 1'b0;
               end else if (t == 8'h2f) mode_in = ckc_pkg::MODE_SLASH;
            end
         end
         ckc_pkg::ST_SEARCH: begin
            if (eq) begin
               st_in = ckc_pkg::ST_UPDATE;
            end else begin
               if (lt) hi_in = {1'b0, mid} - (KW+1)'(1);
               else    lo_in = {1'b0, mid} + (KW+1)'(1);
               if ((lt && mid == '0) || (lt ? lo_ff > {1'b0, mid} - (KW+1)'(1)
                                            : {1'b0, mid} + (KW+1)'(1) > hi_ff))
                  st_in = ckc_pkg::ST_UPDATE;
            end
         end
         ckc_pkg::ST_UPDATE: begin
            cnt_we = eq;
            wchars_in = '0; wlen_in = '0; walpha_in = 1'b0;
            st_in = ckc_pkg::ST_IDLE;
            if (eot_ff) begin
               st_in = ckc_pkg::ST_REPORT; idx_in = '0;
            end
         end
         ckc_pkg::ST_REPORT: begin
            if (!rv_in) begin
               if (nz_ff[idx_ff]) begin
                  rv_in = 1'b1; re_in = 1'b1; rl_in = 1'b0;
                  ri_in = idx_ff; rc_in = cnt_ff[idx_ff];
               end
               if (idx_ff == KW'(ckc_pkg::NumKeys - 1)) st_in = ckc_pkg::ST_MARKER;
               else idx_in = idx_ff + KW'(1);
            end
         end
         ckc_pkg::ST_MARKER: begin
            if (!rv_in) begin
               rv_in = 1'b1; re_in = 1'b0; rl_in = 1'b1; ri_in = '0; rc_in = '0;
               st_in = ckc_pkg::ST_WAIT;
            end
         end
         ckc_pkg::ST_WAIT: begin
            if (!rv_in) begin
               clr_all = 1'b1; eot_in = 1'b0; st_in = ckc_pkg::ST_IDLE;
               mode_in = ckc_pkg::MODE_IDLE; dq_in = 1'b0; esc_in = 1'b0;
               wchars_in = '0; wlen_in = '0; walpha_in = 1'b0; pend_v_in = 1'b0;
            end
         end
         default: st_in = ckc_pkg::ST_IDLE;
      endcase
   end

   // Hold state.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ckc_pkg::ST_IDLE; mode_ff <= ckc_pkg::MODE_IDLE;
         dq_ff <= 1'b0; esc_ff <= 1'b0; wchars_ff <= '0; wlen_ff <= '0;
         walpha_ff <= 1'b0; eot_ff <= 1'b0; pend_v_ff <= 1'b0; rv_ff <= 1'b0;
         nz_ff <= '0;
      end else begin
         st_ff <= st_in; mode_ff <= mode_in; dq_ff <= dq_in; esc_ff <= esc_in;
         wchars_ff <= wchars_in; wlen_ff <= wlen_in; walpha_ff <= walpha_in;
         eot_ff <= eot_in; pend_v_ff <= pend_v_in; rv_ff <= rv_in;
         if (clr_all) nz_ff <= '0;
         else if (cnt_we) nz_ff[cnt_wa] <= 1'b1;
      end
   end

   // Payload registers and counts (a clear entry reads through its valid bit).
   always_ff @(posedge clock) begin
      pend_ff <= pend_in; lo_ff <= lo_in; hi_ff <= hi_in; idx_ff <= idx_in;
      re_ff <= re_in; rl_ff <= rl_in; ri_ff <= ri_in; rc_ff <= rc_in;
      if (cnt_we) begin
         if (!nz_ff[cnt_wa]) cnt_ff[cnt_wa] <= CW'(1);
         else if (cnt_ff[cnt_wa] != '1) cnt_ff[cnt_wa] <= cnt_ff[cnt_wa] + CW'(1);
      end
   end

   `KC_ASSERT_NEVER(a_ready_busy, clock, reset, req_tready && st_ff != ckc_pkg::ST_IDLE)
   `KC_ASSERT_NEVER(a_marker_entry, clock, reset, rsp_tvalid && rsp_tlast && rsp_tuser)
   `KC_ASSERT_IMPL(a_search_done, clock, reset,
      st_ff == ckc_pkg::ST_UPDATE |=> st_ff != ckc_pkg::ST_SEARCH)
endmodule

// ===== verif/tb_c_keyword_counter_top.sv =====
// Self-checking testbench for c_keyword_counter_top: feeds C source bytes and end-of-text
// commands, predicts the keyword reports and checks every response transfer.
// Depends on ckc_pkg and the c_keyword_counter_top RTL.
`timescale 1ns / 1ps
module tb_c_keyword_counter_top;
   localparam int Limit = 400000;

   typedef enum logic [2:0] {
      LX_IDLE, LX_WORD, LX_SLASH, LX_COMMENT, LX_STAR, LX_QUOTE
   } lex_state_type;

   typedef struct packed {
      logic                       entry_valid;
      logic [ckc_pkg::KeyW-1:0]   keyword_index;
      logic [ckc_pkg::CountW-1:0] hit_count;
      logic                       last;
   } report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   c_keyword_counter_top u_top (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Predictor state
   string       kw_names[32] = '{
      "auto", "break", "case", "char", "const", "continue", "default", "do",
      "double", "else", "enum", "extern", "float", "for", "goto", "if",
      "int", "long", "register", "return", "short", "signed", "sizeof", "static",
      "struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"};
   lex_state_type lex;
   logic        in_double;
   logic        esc_pending;
   logic [7:0]  word_buf [8];
   int          word_len;
   logic        word_alpha;
   int unsigned kw_hits [32];
   report_type  report_q [$];

   int          errors = 0;
   int          items_sent = 0;
   int          reports_sent = 0;
   int          results_seen = 0;
   int          cycles = 0;
   int          burst_left = 0;
   int          stall_mode = 0;

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic void lexer_clear();
      lex = LX_IDLE;
      in_double = 1'b0;
      esc_pending = 1'b0;
      word_len = 0;
      word_alpha = 1'b0;
      foreach (word_buf[i]) word_buf[i] = 8'h00;
   endfunction

   // Count the pending word if it is a keyword, then drop it
   function automatic void close_word();
      bit hit;
      lex = LX_IDLE;
      if (word_alpha && word_len <= 8) begin
         for (int k = 0; k < 32; k++) begin
            hit = kw_names[k].len() == word_len;
            for (int i = 0; i < word_len && hit; i++)
               if (kw_names[k].getc(i) != word_buf[i]) hit = 0;
            if (hit && kw_hits[k] < 65535) kw_hits[k]++;
         end
      end
      word_len = 0;
      word_alpha = 1'b0;
      foreach (word_buf[i]) word_buf[i] = 8'h00;
   endfunction

   function automatic void open_token(logic [7:0] c);
      lex = LX_IDLE;
      if (is_blank(c)) return;
      if (is_alpha(c) || c == "_" || c == "#") begin
         lex = LX_WORD;
         word_buf[0] = c;
         word_len = 1;
         word_alpha = is_alpha(c);
      end else if (c == "'" || c == "\"") begin
         lex = LX_QUOTE;
         in_double = (c == "\"");
         esc_pending = 1'b0;
      end else if (c == "/") begin
         lex = LX_SLASH;
      end
   endfunction

   // Advance the predictor by one accepted transfer
   function automatic void lex_byte(logic cmd, logic [7:0] c);
      report_type r;
      if (cmd) begin
         if (lex == LX_WORD) close_word();
         for (int k = 0; k < 32; k++)
            if (kw_hits[k] != 0) begin
               r = '{1'b1, ckc_pkg::KeyW'(k), ckc_pkg::CountW'(kw_hits[k]), 1'b0};
               report_q.push_back(r);
            end
         r = '{1'b0, '0, '0, 1'b1};
         report_q.push_back(r);
         lexer_clear();
         foreach (kw_hits[k]) kw_hits[k] = 0;
         return;
      end
      case (lex)
         LX_WORD: begin
            if ((is_alpha(c) || is_digit(c) || c == "_") &&
                word_len < ckc_pkg::MaxWord - 1) begin
               if (word_len < 8) word_buf[word_len] = c;
               word_len++;
            end else begin
               close_word();
               open_token(c);
            end
         end
         LX_SLASH:   if (c == "*") lex = LX_COMMENT; else open_token(c);
         LX_COMMENT: if (c == "*") lex = LX_STAR;
         LX_STAR: begin
            if (c == "/") lex = LX_IDLE;
            else if (c != "*") lex = LX_COMMENT;
         end
         LX_QUOTE: begin
            if (esc_pending) esc_pending = 1'b0;
            else if (c == "\\") esc_pending = 1'b1;
            else if (c == (in_double ? "\"" : "'")) lex = LX_IDLE;
         end
         default: open_token(c);
      endcase
   endfunction

   // Send one transfer; bursts of random length with random gaps between them
   task automatic send_byte(logic cmd, logic [7:0] c);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      lex_byte(cmd, c);
      items_sent++;
      if (cmd) reports_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(1'b0, s.getc(i));
   endtask

   task automatic send_end();
      send_byte(1'b1, 8'($urandom_range(0, 255)));
   endtask

   // Hold the sender until every expected report has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (report_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // Check each response transfer against the oldest expected report
   always @(posedge clock) begin
      report_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[4:0], rsp_tdata[20:5], rsp_tlast};
         results_seen++;
         if (report_q.size() == 0) begin
            $display("%0t: unexpected response %p", $time, got);
            errors++;
         end else begin
            want = report_q.pop_front();
            if (got != want) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, got);
               errors++;
            end
         end
      end
   end

   // Receiver stall pattern: ready stretches, random stalls or a slow phase, switched at random
   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 9) > 2);
         default: rsp_tready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > Limit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic test_keywords();
      send_text("int x;auto while/**/");
      send_end();
   endtask

   task automatic test_comments_and_slash();
      send_text("/***/do/a/ **/if");
      send_end();
   endtask

   task automatic test_literals();
      send_text("\"\\\"if\"for'\\''");
      send_end();
   endtask

   task automatic test_classes();
      send_text("#if else_");
      send_byte(1'b0, 8'hff);
      send_byte(1'b0, 8'h00);
      send_text("case");
      send_end();
   endtask

   task automatic test_end_inside();
      send_text("char/*");
      send_end();
      send_text("\"x");
      send_end();
      send_text("goto");
      send_end();
   endtask

   // Split at MAX_WORD-1, an overlong keyword prefix and a lone digit after a split
   task automatic test_long_words();
      send_text("unsignedx ");
      repeat (ckc_pkg::MaxWord - 1) send_byte(1'b0, "a");
      send_text("int ");
      repeat (ckc_pkg::MaxWord - 1) send_byte(1'b0, "b");
      send_text("9 void");
      send_end();
   endtask

   task automatic send_fragment();
      int k;
      string sep [6] = '{" ", "\n", "\t", ";", "(", ","};
      k = $urandom_range(0, 31);
      case ($urandom_range(0, 11))
         0, 1, 2, 3: send_text({kw_names[k], sep[$urandom_range(0, 5)]});
         4: send_text({kw_names[k], "_", sep[$urandom_range(0, 5)]});
         5: begin
            send_text("/*");
            repeat ($urandom_range(0, 4))
               send_byte(1'b0, ($urandom_range(0, 2) == 0) ? 8'h2a
                                                            : 8'($urandom_range(0, 255)));
            send_text("*/");
         end
         6: begin
            send_byte(1'b0, "\"");
            repeat ($urandom_range(0, 4))
               send_byte(1'b0, ($urandom_range(0, 3) == 0) ? 8'h5c
                                                           : 8'($urandom_range(32, 126)));
            send_text("\"\" ");
         end
         7: send_text({"'", kw_names[k], "' "});
         8: send_text({"/", kw_names[k], " "});
         9: send_text({"#", kw_names[k], " x1 "});
         10: send_byte(1'b0, 8'($urandom_range(0, 255)));
         default: send_text({"v", kw_names[k], "9 "});
      endcase
   endtask

   task automatic test_random();
      int pause_at;
      pause_at = 100 + $urandom_range(0, 200);
      while (items_sent < 480) begin
         send_fragment();
         if ($urandom_range(0, 15) == 0) send_end();
         if (items_sent > pause_at) begin
            pause_at = 1 << 30;
            drain();
         end
      end
      send_end();
   endtask

   initial begin
      lexer_clear();
      foreach (kw_hits[k]) kw_hits[k] = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_keywords();
      test_comments_and_slash();
      test_literals();
      test_classes();
      test_end_inside();
      drain();
      test_long_words();
      test_random();
      drain();
      $display("Covered %0d input transfers, %0d end-of-text reports, %0d responses checked",
               items_sent, reports_sent, results_seen);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ckc_pkg.sv
rtl/core/c_keyword_counter_top.sv
verif/tb_c_keyword_counter_top.sv
